// File: hdl/bmhq_pkg.sv
// ============================================================================
// bmhq_pkg
// Shared types, sizes and helpers for the binary min-heap queue: entry
// layout, level/index mapping of heap positions, request and response buses.
// ============================================================================

package bmhq_pkg;

    // heap size and derived widths
    localparam int CAPACITY = 256;
    localparam int PW       = $clog2(CAPACITY + 1);   // position / count width
    localparam int LEVELS   = PW;                     // tree levels, root is level 0
    localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int IW       = LEVELS - 1;             // index width within a level
    localparam int OCC_W    = 9;                      // occupancy field width

    typedef logic [PW-1:0] pos_t;
    typedef logic [LW-1:0] lvl_t;
    typedef logic [IW-1:0] idx_t;

    // request opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // one heap entry
    typedef struct packed {
        logic signed [31:0] key;
        logic [7:0]         item;
    } entry_t;

    // read request broadcast along the cell row
    typedef struct packed {
        logic en;
        lvl_t lvl;
        idx_t idx_a;
        idx_t idx_b;
    } rd_req_t;

    // write request broadcast along the cell row
    typedef struct packed {
        logic   en;
        lvl_t   lvl;
        idx_t   idx;
        entry_t data;
    } wr_req_t;

    // read data travelling back toward the root cell
    typedef struct packed {
        entry_t a;
        entry_t b;
    } rd_rsp_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DEL_ROOT,
        S_DEL_LAST,
        S_DEL_MOVE,
        S_UPD_ROOT,
        S_UPD_CHK,
        S_SCAN,
        S_RM_RD,
        S_RM_LAST,
        S_RM_PAR,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_FIN,
        S_OUT
    } state_t;

    // signed key compare, a strictly below b
    function automatic logic key_lt(logic signed [31:0] a, logic signed [31:0] b);
        return a < b;
    endfunction

    // level of a heap position (index of its top set bit)
    function automatic lvl_t pos_lvl(pos_t p);
        lvl_t l;
        l = '0;
        for (int b = 0; b < PW; b++) begin
            if (p[b]) begin
                l = LW'(b);
            end
        end
        return l;
    endfunction

    // index of a heap position within its level
    function automatic idx_t pos_idx(pos_t p);
        pos_t one;
        pos_t m;
        one = pos_t'(1);
        m   = p ^ (one << pos_lvl(p));
        return m[IW-1:0];
    endfunction

endpackage

// File: hdl/bmhq_ram.sv
// ============================================================================
// bmhq_ram
// Storage of one heap level: one write port, two read ports, registered
// read data.
// ============================================================================

module bmhq_ram import bmhq_pkg::*; #(
    parameter int  DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  entry_t                 wr_data,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr_a,
    input  logic [AW-1:0]          rd_addr_b,
    output entry_t                 rd_data_a,
    output entry_t                 rd_data_b
);

    entry_t mem [DEPTH];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // two registered read ports
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// File: hdl/bmhq_cell.sv
// ============================================================================
// bmhq_cell
// One level cell of the heap row: claims the requests aimed at its level,
// drives its level store, and passes read data from the deeper cell up
// toward the root unless it answers the read itself.
// ============================================================================

module bmhq_cell import bmhq_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  lvl_t    cell_lvl,
    input  rd_req_t rd_req,
    input  wr_req_t wr_req,
    input  rd_rsp_t chain_in,
    output rd_rsp_t chain_out,
    output logic    ram_rd_en,
    output idx_t    ram_rd_idx_a,
    output idx_t    ram_rd_idx_b,
    output logic    ram_wr_en,
    output idx_t    ram_wr_idx,
    output entry_t  ram_wr_data,
    input  entry_t  ram_rd_a,
    input  entry_t  ram_rd_b
);

    logic sel_reg;
    logic sel_next;

    // level decode
    always_comb begin
        ram_rd_en    = rd_req.en && (rd_req.lvl == cell_lvl);
        ram_rd_idx_a = rd_req.idx_a;
        ram_rd_idx_b = rd_req.idx_b;
        ram_wr_en    = wr_req.en && (wr_req.lvl == cell_lvl);
        ram_wr_idx   = wr_req.idx;
        ram_wr_data  = wr_req.data;
        sel_next     = ram_rd_en;
    end

    // remember which cell answers the read in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
        end
    end

    // read data hop toward the root
    always_comb begin
        if (sel_reg) begin
            chain_out.a = ram_rd_a;
            chain_out.b = ram_rd_b;
        end else begin
            chain_out = chain_in;
        end
    end

endmodule

// File: hdl/bmhq_ctrl.sv
// ============================================================================
// bmhq_ctrl
// Request sequencer: decodes insert, delete-min and update, walks sift-up,
// sift-down and the id search over the cell row, and holds the result beat.
// ============================================================================

module bmhq_ctrl import bmhq_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic signed [31:0] s_key,
    input  logic [7:0]         s_item_id,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_item,
    output logic signed [31:0] m_out_key,
    output logic [1:0]         m_status,
    output logic [OCC_W-1:0]   m_occupancy,
    output rd_req_t            rd_req,
    output wr_req_t            wr_req,
    input  rd_rsp_t            rd_rsp
);

    // control state
    state_t state_reg, state_next;
    pos_t   cnt_reg, cnt_next;
    logic   m_valid_reg, m_valid_next;

    // working payload
    pos_t               pos_reg, pos_next;
    pos_t               found_reg, found_next;
    pos_t               scan_reg, scan_next;
    logic               phase_reg, phase_next;
    entry_t             mov_reg, mov_next;
    logic signed [31:0] key_reg, key_next;
    logic [7:0]         id_reg, id_next;
    logic [7:0]         res_item_reg, res_item_next;
    logic signed [31:0] res_key_reg, res_key_next;
    logic [1:0]         res_st_reg, res_st_next;
    logic [7:0]         m_item_reg, m_item_next;
    logic signed [31:0] m_key_reg, m_key_next;
    logic [1:0]         m_st_reg, m_st_next;
    logic [OCC_W-1:0]   m_occ_reg, m_occ_next;

    // memory access of this cycle
    logic   rd_en;
    logic   rd_pair;
    pos_t   rd_pos;
    logic   wr_en;
    pos_t   wr_pos;
    entry_t wr_data;

    // helpers
    logic [PW:0] cnt_x;
    logic [PW:0] c0;
    logic [PW:0] c1;
    logic [PW:0] scan_p0;
    logic [PW:0] scan_p1;
    logic        take_r;
    entry_t      child;
    entry_t      new_entry;

    always_comb begin
        cnt_x     = {1'b0, cnt_reg};
        c0        = {pos_reg, 1'b0};
        c1        = c0 + (PW+1)'(1);
        scan_p0   = {scan_reg, 1'b0};
        scan_p1   = scan_p0 + (PW+1)'(1);
        take_r    = (c1 <= cnt_x) && key_lt(rd_rsp.b.key, rd_rsp.a.key);
        child     = take_r ? rd_rsp.b : rd_rsp.a;
        new_entry = '{key: key_reg, item: id_reg};
    end

    // next state and datapath
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        pos_next      = pos_reg;
        found_next    = found_reg;
        scan_next     = scan_reg;
        phase_next    = phase_reg;
        mov_next      = mov_reg;
        key_next      = key_reg;
        id_next       = id_reg;
        res_item_next = res_item_reg;
        res_key_next  = res_key_reg;
        res_st_next   = res_st_reg;
        m_item_next   = m_item_reg;
        m_key_next    = m_key_reg;
        m_st_next     = m_st_reg;
        m_occ_next    = m_occ_reg;
        rd_en         = 1'b0;
        rd_pair       = 1'b0;
        rd_pos        = pos_t'(1);
        wr_en         = 1'b0;
        wr_pos        = pos_reg;
        wr_data       = mov_reg;
        s_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    key_next      = s_key;
                    id_next       = s_item_id;
                    res_item_next = '0;
                    res_key_next  = '0;
                    res_st_next   = ST_OK;
                    phase_next    = 1'b0;
                    unique case (s_opcode)
                        OP_INSERT: begin
                            if (cnt_reg == pos_t'(CAPACITY)) begin
                                res_st_next = ST_FULL;
                                state_next  = S_OUT;
                            end else begin
                                cnt_next   = cnt_reg + pos_t'(1);
                                pos_next   = cnt_reg + pos_t'(1);
                                mov_next   = '{key: s_key, item: s_item_id};
                                state_next = S_UP_RD;
                            end
                        end
                        OP_DELETE: begin
                            if (cnt_reg == '0) begin
                                res_st_next = ST_EMPTY;
                                state_next  = S_OUT;
                            end else begin
                                state_next = S_DEL_ROOT;
                            end
                        end
                        OP_UPDATE: begin
                            if (cnt_reg == '0) begin
                                res_st_next = ST_EMPTY;
                                state_next  = S_OUT;
                            end else begin
                                state_next = S_UPD_ROOT;
                            end
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            // delete-min: fetch root, then the last entry
            S_DEL_ROOT: begin
                rd_en      = 1'b1;
                rd_pos     = pos_t'(1);
                state_next = S_DEL_LAST;
            end
            S_DEL_LAST: begin
                res_item_next = rd_rsp.a.item;
                res_key_next  = rd_rsp.a.key;
                rd_en         = 1'b1;
                rd_pos        = cnt_reg;
                state_next    = S_DEL_MOVE;
            end
            S_DEL_MOVE: begin
                mov_next = rd_rsp.a;
                cnt_next = cnt_reg - pos_t'(1);
                if (cnt_reg == pos_t'(1)) begin
                    state_next = S_OUT;
                end else begin
                    pos_next   = pos_t'(1);
                    state_next = S_DN_RD;
                end
            end

            // update: id search, root first, then position pairs in array order
            S_UPD_ROOT: begin
                rd_en      = 1'b1;
                rd_pos     = pos_t'(1);
                state_next = S_UPD_CHK;
            end
            S_UPD_CHK: begin
                if (rd_rsp.a.item == id_reg) begin
                    found_next = pos_t'(1);
                    state_next = S_RM_RD;
                end else if (cnt_reg == pos_t'(1)) begin
                    res_st_next = ST_NOT_FOUND;
                    state_next  = S_OUT;
                end else begin
                    scan_next  = pos_t'(1);
                    rd_en      = 1'b1;
                    rd_pair    = 1'b1;
                    rd_pos     = pos_t'(2);
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_rsp.a.item == id_reg) begin
                    found_next = pos_t'(scan_p0);
                    state_next = S_RM_RD;
                end else if ((rd_rsp.b.item == id_reg) && (scan_p1 <= cnt_x)) begin
                    found_next = pos_t'(scan_p1);
                    state_next = S_RM_RD;
                end else if (scan_p1 >= cnt_x) begin
                    res_st_next = ST_NOT_FOUND;
                    state_next  = S_OUT;
                end else begin
                    scan_next = scan_reg + pos_t'(1);
                    rd_en     = 1'b1;
                    rd_pair   = 1'b1;
                    rd_pos    = pos_t'(scan_p0 + (PW+1)'(2));
                end
            end

            // removal of the found entry
            S_RM_RD: begin
                rd_en      = 1'b1;
                rd_pos     = cnt_reg;
                state_next = S_RM_LAST;
            end
            S_RM_LAST: begin
                if (found_reg == cnt_reg) begin
                    // found entry is the last one: drop it and reinsert in place
                    pos_next   = cnt_reg;
                    mov_next   = new_entry;
                    state_next = S_UP_RD;
                end else begin
                    mov_next   = rd_rsp.a;
                    cnt_next   = cnt_reg - pos_t'(1);
                    phase_next = 1'b1;
                    pos_next   = found_reg;
                    if (found_reg > pos_t'(1)) begin
                        rd_en      = 1'b1;
                        rd_pos     = found_reg >> 1;
                        state_next = S_RM_PAR;
                    end else begin
                        state_next = S_DN_RD;
                    end
                end
            end
            S_RM_PAR: begin
                if (key_lt(mov_reg.key, rd_rsp.a.key)) begin
                    wr_en      = 1'b1;
                    wr_data    = rd_rsp.a;
                    pos_next   = pos_reg >> 1;
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_DN_RD;
                end
            end

            // sift up, one level per read/compare pair
            S_UP_RD: begin
                if (pos_reg == pos_t'(1)) begin
                    state_next = S_FIN;
                end else begin
                    rd_en      = 1'b1;
                    rd_pos     = pos_reg >> 1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (key_lt(mov_reg.key, rd_rsp.a.key)) begin
                    wr_en      = 1'b1;
                    wr_data    = rd_rsp.a;
                    pos_next   = pos_reg >> 1;
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_FIN;
                end
            end

            // sift down, both children read together as one pair
            S_DN_RD: begin
                if (c0 <= cnt_x) begin
                    rd_en      = 1'b1;
                    rd_pair    = 1'b1;
                    rd_pos     = pos_t'(c0);
                    state_next = S_DN_CMP;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_DN_CMP: begin
                if (key_lt(child.key, mov_reg.key)) begin
                    wr_en      = 1'b1;
                    wr_data    = child;
                    pos_next   = pos_t'(c0 | {{PW{1'b0}}, take_r});
                    state_next = S_DN_RD;
                end else begin
                    state_next = S_FIN;
                end
            end

            // place the moving entry; an update then reinserts with its new key
            S_FIN: begin
                wr_en = 1'b1;
                if (phase_reg) begin
                    phase_next = 1'b0;
                    cnt_next   = cnt_reg + pos_t'(1);
                    pos_next   = cnt_reg + pos_t'(1);
                    mov_next   = new_entry;
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_OUT;
                end
            end

            // hand the result to the output register
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_item_reg;
                    m_key_next   = res_key_reg;
                    m_st_next    = res_st_reg;
                    m_occ_next   = OCC_W'(cnt_reg);
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // request buses toward the cell row
    always_comb begin
        rd_req.en    = rd_en;
        rd_req.lvl   = pos_lvl(rd_pos);
        rd_req.idx_a = pos_idx(rd_pos);
        rd_req.idx_b = rd_pair ? (pos_idx(rd_pos) | idx_t'(1)) : pos_idx(rd_pos);
        wr_req.en    = wr_en;
        wr_req.lvl   = pos_lvl(wr_pos);
        wr_req.idx   = pos_idx(wr_pos);
        wr_req.data  = wr_data;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        scan_reg     <= scan_next;
        phase_reg    <= phase_next;
        mov_reg      <= mov_next;
        key_reg      <= key_next;
        id_reg       <= id_next;
        res_item_reg <= res_item_next;
        res_key_reg  <= res_key_next;
        res_st_reg   <= res_st_next;
        m_item_reg   <= m_item_next;
        m_key_reg    <= m_key_next;
        m_st_reg     <= m_st_next;
        m_occ_reg    <= m_occ_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_item  = m_item_reg;
    assign m_out_key   = m_key_reg;
    assign m_status    = m_st_reg;
    assign m_occupancy = m_occ_reg;

endmodule

// File: hdl/binary_min_heap_queue.sv
// ============================================================================
// binary_min_heap_queue
// Binary min-heap of (key, item id) pairs built as a row of level cells,
// one cell and one level store per tree level, driven by a request sequencer.
// ============================================================================
//
//  channel  dir  handshake          payload
//  s_       in   s_valid / s_ready  s_opcode, s_key, s_item_id
//  m_       out  m_valid / m_ready  m_out_item, m_out_key, m_status, m_occupancy
//
//  From the accepted request to m_valid, one request at a time:
//  insert reads and compares one parent per level climbed, then places the entry;
//  delete-min reads the root and the last entry, then sifts down by child pairs;
//  update searches root, then position pairs, then removes and reinserts; errors
//  and the unused opcode go to the result. Reset clears state, count and m_valid.
//  A waiting result lets the next request in; its result holds until the beat goes.

module binary_min_heap_queue import bmhq_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic signed [31:0] s_key,
    input  logic [7:0]         s_item_id,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_item,
    output logic signed [31:0] m_out_key,
    output logic [1:0]         m_status,
    output logic [OCC_W-1:0]   m_occupancy
);

    rd_req_t rd_req;
    wr_req_t wr_req;
    rd_rsp_t chain [LEVELS+1];

    // sequencer
    bmhq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_key       (s_key),
        .s_item_id   (s_item_id),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_item  (m_out_item),
        .m_out_key   (m_out_key),
        .m_status    (m_status),
        .m_occupancy (m_occupancy),
        .rd_req      (rd_req),
        .wr_req      (wr_req),
        .rd_rsp      (chain[0])
    );

    // deepest cell has nothing below it
    assign chain[LEVELS] = '0;

    // one cell and store per level
    for (genvar g = 0; g < LEVELS; g++) begin : g_level
        localparam int LVL_BASE  = 1 << g;
        localparam int LVL_DEPTH = ((CAPACITY - LVL_BASE + 1) < LVL_BASE) ?
                                   (CAPACITY - LVL_BASE + 1) : LVL_BASE;
        localparam int LVL_AW    = (LVL_DEPTH > 1) ? $clog2(LVL_DEPTH) : 1;

        logic   ram_rd_en;
        logic   ram_wr_en;
        idx_t   ram_rd_idx_a;
        idx_t   ram_rd_idx_b;
        idx_t   ram_wr_idx;
        entry_t ram_wr_data;
        entry_t ram_rd_a;
        entry_t ram_rd_b;

        bmhq_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cell_lvl     (LW'(g)),
            .rd_req       (rd_req),
            .wr_req       (wr_req),
            .chain_in     (chain[g+1]),
            .chain_out    (chain[g]),
            .ram_rd_en    (ram_rd_en),
            .ram_rd_idx_a (ram_rd_idx_a),
            .ram_rd_idx_b (ram_rd_idx_b),
            .ram_wr_en    (ram_wr_en),
            .ram_wr_idx   (ram_wr_idx),
            .ram_wr_data  (ram_wr_data),
            .ram_rd_a     (ram_rd_a),
            .ram_rd_b     (ram_rd_b)
        );

        bmhq_ram #(
            .DEPTH (LVL_DEPTH)
        ) u_ram (
            .aclk      (aclk),
            .wr_en     (ram_wr_en),
            .wr_addr   (ram_wr_idx[LVL_AW-1:0]),
            .wr_data   (ram_wr_data),
            .rd_en     (ram_rd_en),
            .rd_addr_a (ram_rd_idx_a[LVL_AW-1:0]),
            .rd_addr_b (ram_rd_idx_b[LVL_AW-1:0]),
            .rd_data_a (ram_rd_a),
            .rd_data_b (ram_rd_b)
        );
    end

    // one request in flight: an accepted beat drops ready next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in flight");

    // only a successful delete-min carries an item and key
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> ((m_out_item == '0) && (m_out_key == '0)))
        else $error("error result carries a removed entry");

    // occupancy never exceeds the heap size
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_occupancy) <= CAPACITY))
        else $error("occupancy beyond capacity");

endmodule
